// ----- sv/bfsp_pkg.sv -----
// Shared types and constants for the Bellman-Ford shortest path block.
// Used by the controller, the datapath and the top level.
package bfsp_pkg;

   localparam int MAX_VERTICES_DEF = 32;
   localparam int MAX_EDGES_DEF    = 256;

   localparam int ID_W     = 5;
   localparam int WEIGHT_W = 16;
   localparam int DIST_W   = 32;
   localparam int VC_W     = 6;
   localparam int EDGE_W   = 2 * ID_W + WEIGHT_W;

   localparam logic [VC_W-1:0] VC_RESET  = 6'd5;
   localparam logic [ID_W-1:0] SRC_RESET = 5'd1;

   localparam int CSR_ADDR_W = 3;
   localparam logic CSR_IDX_VC  = 1'b0;
   localparam logic CSR_IDX_SRC = 1'b1;

   typedef enum logic [2:0] {
      ST_LOAD,
      ST_INIT,
      ST_FETCH,
      ST_DREAD,
      ST_RELAX,
      ST_VREAD,
      ST_VLOAD,
      ST_VSHOW
   } state_type;

   typedef struct packed {
      logic load;
      logic init;
      logic fetch;
      logic dread;
      logic relax;
      logic vread;
      logic vload;
      logic vnext;
      logic finish;
   } cmd_type;

   typedef struct packed {
      logic no_pass;
      logic relax_last;
      logic vert_last;
   } status_type;

endpackage

// ----- sv/bellman_ford_shortest_paths_top.sv -----
// Edges load at one per cycle. The last edge starts a run of an init state,
// then fetch, dread and relax states for each stored edge in each of
// (vertex_count - 1) passes, with vertex_count clamped to 1..MAX_VERTICES.
// Each result takes vread, vload and vshow states plus any output stall;
// input is held off during the run. Reset empties the edge store, sets
// vertex_count 5 and source_vertex 1; no clearing pass is needed.
module bellman_ford_shortest_paths_top
   import bfsp_pkg::*;
#(
   parameter int MAX_VERTICES = MAX_VERTICES_DEF,
   parameter int MAX_EDGES    = MAX_EDGES_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   // tdata: edge_tail[4:0], edge_head[9:5], edge_weight[25:10], zero pad
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [31:0]           req_tdata,
   input  logic                  req_tlast,
   // tdata: vertex_id[4:0], path_distance[36:5], reached[37],
   //        parent_vertex[42:38], has_parent[43], edges_dropped[44], zero pad
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [47:0]           rsp_tdata,
   output logic                  rsp_tlast,
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [31:0]           csr_pwdata,
   output logic [31:0]           csr_prdata,
   output logic                  csr_pready
);

   logic [VC_W-1:0] vc_ff;
   logic [ID_W-1:0] src_ff;
   logic            csr_wr;

   cmd_type    cmd;
   status_type status;

   logic [ID_W-1:0]   vertex_id;
   logic [DIST_W-1:0] path_distance;
   logic              reached;
   logic [ID_W-1:0]   parent_vertex;
   logic              has_parent;
   logic              edges_dropped;

   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         vc_ff  <= VC_RESET;
         src_ff <= SRC_RESET;
      end else if (csr_wr) begin
         if (csr_paddr[2] == CSR_IDX_VC) begin
            vc_ff <= csr_pwdata[VC_W-1:0];
         end else begin
            src_ff <= csr_pwdata[ID_W-1:0];
         end
      end
   end

   assign csr_prdata = (csr_paddr[2] == CSR_IDX_SRC) ? {{(32-ID_W){1'b0}}, src_ff}
                                                     : {{(32-VC_W){1'b0}}, vc_ff};

   bfsp_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tlast  (req_tlast),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .status     (status),
      .cmd        (cmd)
   );

   bfsp_dp #(
      .MAX_VERTICES (MAX_VERTICES),
      .MAX_EDGES    (MAX_EDGES)
   ) u_dp (
      .clock         (clock),
      .reset         (reset),
      .vertex_count  (vc_ff),
      .source_vertex (src_ff),
      .edge_in       (req_tdata[EDGE_W-1:0]),
      .cmd           (cmd),
      .status        (status),
      .vertex_id     (vertex_id),
      .path_distance (path_distance),
      .reached       (reached),
      .parent_vertex (parent_vertex),
      .has_parent    (has_parent),
      .edges_dropped (edges_dropped),
      .last_vertex   (rsp_tlast)
   );

   assign rsp_tdata = {3'b000, edges_dropped, has_parent, parent_vertex, reached,
                       path_distance, vertex_id};

endmodule

// ----- sv/bfsp_ram.sv -----
// Generic single write port, single read port RAM with registered read.
// No dependencies.
module bfsp_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                                    clock,
   input  logic                                    we,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
   input  logic [WIDTH-1:0]                        wdata,
   input  logic                                    re,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
   output logic [WIDTH-1:0]                        rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem_ff[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

// ----- sv/bfsp_ctrl.sv -----
// Sequencer for load, relaxation passes and result output.
// Depends on bfsp_pkg; drives the datapath through cmd_type.
module bfsp_ctrl
   import bfsp_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_tvalid,
   input  logic       req_tlast,
   output logic       req_tready,
   output logic       rsp_tvalid,
   input  logic       rsp_tready,
   input  status_type status,
   output cmd_type    cmd
);

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_LOAD;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_LOAD: begin
            if (req_tvalid && req_tlast) state_in = ST_INIT;
         end
         ST_INIT: begin
            state_in = status.no_pass ? ST_VREAD : ST_FETCH;
         end
         ST_FETCH: state_in = ST_DREAD;
         ST_DREAD: state_in = ST_RELAX;
         ST_RELAX: begin
            state_in = status.relax_last ? ST_VREAD : ST_FETCH;
         end
         ST_VREAD: state_in = ST_VLOAD;
         ST_VLOAD: state_in = ST_VSHOW;
         ST_VSHOW: begin
            if (rsp_tready) state_in = status.vert_last ? ST_LOAD : ST_VREAD;
         end
         default: state_in = ST_LOAD;
      endcase
   end

   always_comb begin
      cmd        = '0;
      req_tready = 1'b0;
      rsp_tvalid = 1'b0;
      case (state_ff)
         ST_LOAD: begin
            req_tready = 1'b1;
            cmd.load   = req_tvalid;
         end
         ST_INIT:  cmd.init  = 1'b1;
         ST_FETCH: cmd.fetch = 1'b1;
         ST_DREAD: cmd.dread = 1'b1;
         ST_RELAX: cmd.relax = 1'b1;
         ST_VREAD: cmd.vread = 1'b1;
         ST_VLOAD: cmd.vload = 1'b1;
         ST_VSHOW: begin
            rsp_tvalid = 1'b1;
            cmd.vnext  = rsp_tready && !status.vert_last;
            cmd.finish = rsp_tready && status.vert_last;
         end
         default: cmd = '0;
      endcase
   end

endmodule

// ----- sv/bfsp_dp.sv -----
// Datapath: edge store, distance and parent tables, relaxation and results.
// Depends on bfsp_pkg and bfsp_ram; commanded by bfsp_ctrl.
module bfsp_dp
   import bfsp_pkg::*;
#(
   parameter int MAX_VERTICES = MAX_VERTICES_DEF,
   parameter int MAX_EDGES    = MAX_EDGES_DEF
) (
   input  logic                clock,
   input  logic                reset,
   input  logic [VC_W-1:0]     vertex_count,
   input  logic [ID_W-1:0]     source_vertex,
   input  logic [EDGE_W-1:0]   edge_in,
   input  cmd_type             cmd,
   output status_type          status,
   output logic [ID_W-1:0]     vertex_id,
   output logic [DIST_W-1:0]   path_distance,
   output logic                reached,
   output logic [ID_W-1:0]     parent_vertex,
   output logic                has_parent,
   output logic                edges_dropped,
   output logic                last_vertex
);

   localparam int VW = $clog2(MAX_VERTICES);
   localparam int VN = 1 << VW;
   localparam int NW = $clog2(MAX_VERTICES + 1);
   localparam int CW = (NW > VC_W) ? NW : VC_W;
   localparam int AW = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;
   localparam int EW = $clog2(MAX_EDGES + 1);

   logic [EW-1:0]  count_ff, count_in;
   logic [EW-1:0]  e_ff, e_in;
   logic [NW-1:0]  pass_ff, pass_in;
   logic [NW-1:0]  v_ff, v_in;
   logic           ovf_ff, ovf_in;
   logic [VN-1:0]  reach_ff, reach_in;
   logic [VN-1:0]  pval_ff, pval_in;

   logic [CW-1:0]  n_c;
   logic           src_ok;
   logic           full;
   logic           edge_last;

   logic [EDGE_W-1:0] edge_q;
   logic [ID_W-1:0]   e_tail, e_head;
   logic [WEIGHT_W-1:0] e_weight;
   logic [VW-1:0]     tail_idx, head_idx, src_idx, v_idx;
   logic [DIST_W-1:0] dist_a, dist_b;
   logic [ID_W-1:0]   par_q;
   logic [DIST_W:0]   sum;
   logic [DIST_W-1:0] cand;
   logic              edge_ok, upd;

   logic              dw_en;
   logic [VW-1:0]     dw_addr;
   logic [DIST_W-1:0] dw_data;
   logic [VW-1:0]     da_raddr;

   logic [ID_W-1:0]   vid_ff;
   logic [DIST_W-1:0] dist_ff;
   logic              reached_ff, haspar_ff, last_ff;
   logic [ID_W-1:0]   par_ff;

   always_comb begin
      if (vertex_count == '0) begin
         n_c = CW'(1);
      end else if (CW'(vertex_count) > CW'(MAX_VERTICES)) begin
         n_c = CW'(MAX_VERTICES);
      end else begin
         n_c = CW'(vertex_count);
      end
   end

   assign src_ok    = CW'(source_vertex) < n_c;
   assign full      = count_ff == EW'(MAX_EDGES);
   assign edge_last = (e_ff + EW'(1)) == count_ff;

   assign e_tail   = edge_q[ID_W-1:0];
   assign e_head   = edge_q[2*ID_W-1:ID_W];
   assign e_weight = edge_q[EDGE_W-1:2*ID_W];
   assign tail_idx = VW'(e_tail);
   assign head_idx = VW'(e_head);
   assign src_idx  = VW'(source_vertex);
   assign v_idx    = v_ff[VW-1:0];

   assign sum = {dist_a[DIST_W-1], dist_a} +
                {{(DIST_W + 1 - WEIGHT_W){e_weight[WEIGHT_W-1]}}, e_weight};

   always_comb begin
      if (sum[DIST_W] != sum[DIST_W-1]) begin
         cand = sum[DIST_W] ? {1'b1, {(DIST_W-1){1'b0}}} : {1'b0, {(DIST_W-1){1'b1}}};
      end else begin
         cand = sum[DIST_W-1:0];
      end
   end

   assign edge_ok = (CW'(e_tail) < n_c) && (CW'(e_head) < n_c) && reach_ff[tail_idx];
   assign upd     = edge_ok && (!reach_ff[head_idx] || ($signed(dist_b) > $signed(cand)));

   assign dw_en    = (cmd.init && src_ok) || (cmd.relax && upd);
   assign dw_addr  = cmd.init ? src_idx : head_idx;
   assign dw_data  = cmd.init ? '0 : cand;
   assign da_raddr = cmd.vread ? v_idx : tail_idx;

   bfsp_ram #(.WIDTH(EDGE_W), .DEPTH(MAX_EDGES)) u_edge_ram (
      .clock (clock),
      .we    (cmd.load && !full),
      .waddr (count_ff[AW-1:0]),
      .wdata (edge_in),
      .re    (cmd.fetch),
      .raddr (e_ff[AW-1:0]),
      .rdata (edge_q)
   );

   bfsp_ram #(.WIDTH(DIST_W), .DEPTH(MAX_VERTICES)) u_dist_a_ram (
      .clock (clock),
      .we    (dw_en),
      .waddr (dw_addr),
      .wdata (dw_data),
      .re    (cmd.dread || cmd.vread),
      .raddr (da_raddr),
      .rdata (dist_a)
   );

   bfsp_ram #(.WIDTH(DIST_W), .DEPTH(MAX_VERTICES)) u_dist_b_ram (
      .clock (clock),
      .we    (dw_en),
      .waddr (dw_addr),
      .wdata (dw_data),
      .re    (cmd.dread),
      .raddr (head_idx),
      .rdata (dist_b)
   );

   bfsp_ram #(.WIDTH(ID_W), .DEPTH(MAX_VERTICES)) u_parent_ram (
      .clock (clock),
      .we    (cmd.relax && upd),
      .waddr (head_idx),
      .wdata (e_tail),
      .re    (cmd.vread),
      .raddr (v_idx),
      .rdata (par_q)
   );

   always_comb begin
      count_in = count_ff;
      ovf_in   = ovf_ff;
      e_in     = e_ff;
      pass_in  = pass_ff;
      v_in     = v_ff;
      reach_in = reach_ff;
      pval_in  = pval_ff;
      if (cmd.load) begin
         if (full) begin
            ovf_in = 1'b1;
         end else begin
            count_in = count_ff + EW'(1);
         end
      end
      if (cmd.init) begin
         e_in     = '0;
         pass_in  = '0;
         v_in     = '0;
         reach_in = '0;
         pval_in  = '0;
         if (src_ok) reach_in[src_idx] = 1'b1;
      end
      if (cmd.relax) begin
         if (edge_last) begin
            e_in    = '0;
            pass_in = pass_ff + NW'(1);
         end else begin
            e_in = e_ff + EW'(1);
         end
         if (upd) begin
            reach_in[head_idx] = 1'b1;
            pval_in[head_idx]  = 1'b1;
         end
      end
      if (cmd.vnext) v_in = v_ff + NW'(1);
      if (cmd.finish) begin
         count_in = '0;
         ovf_in   = 1'b0;
         v_in     = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         ovf_ff   <= 1'b0;
         e_ff     <= '0;
         pass_ff  <= '0;
         v_ff     <= '0;
         reach_ff <= '0;
         pval_ff  <= '0;
      end else begin
         count_ff <= count_in;
         ovf_ff   <= ovf_in;
         e_ff     <= e_in;
         pass_ff  <= pass_in;
         v_ff     <= v_in;
         reach_ff <= reach_in;
         pval_ff  <= pval_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.vload) begin
         vid_ff     <= ID_W'(v_ff);
         reached_ff <= reach_ff[v_idx];
         dist_ff    <= reach_ff[v_idx] ? dist_a : '0;
         haspar_ff  <= pval_ff[v_idx];
         par_ff     <= pval_ff[v_idx] ? par_q : '0;
         last_ff    <= (CW'(v_ff) + CW'(1)) == n_c;
      end
   end

   assign status.no_pass    = n_c == CW'(1);
   assign status.relax_last = edge_last && ((CW'(pass_ff) + CW'(2)) == n_c);
   assign status.vert_last  = last_ff;

   assign vertex_id     = vid_ff;
   assign path_distance = dist_ff;
   assign reached       = reached_ff;
   assign parent_vertex = par_ff;
   assign has_parent    = haspar_ff;
   assign edges_dropped = ovf_ff;
   assign last_vertex   = last_ff;

endmodule

// ----- tb/bellman_ford_shortest_paths_top_tb.sv -----
// Self-checking testbench for bellman_ford_shortest_paths_top: streams edge
// requests, programs vertex_count and source_vertex over the register port, and
// checks every vertex result against a shortest-path predictor. Needs bfsp_pkg.
module bellman_ford_shortest_paths_top_tb;
   import bfsp_pkg::*;

   localparam int ARC_CAP     = MAX_EDGES_DEF;
   localparam int VTX_CAP     = MAX_VERTICES_DEF;
   localparam int IDLE_LIMIT  = 50000;
   localparam int RANDOM_ARCS = 90;
   localparam int SETTLE      = 8;

   localparam logic [CSR_ADDR_W-1:0] VC_ADDR  = {CSR_IDX_VC, 2'b00};
   localparam logic [CSR_ADDR_W-1:0] SRC_ADDR = {CSR_IDX_SRC, 2'b00};

   typedef struct {
      logic [ID_W-1:0]          vertex;
      logic signed [DIST_W-1:0] distance;
      logic                     reached;
      logic [ID_W-1:0]          parent;
      logic                     has_parent;
      logic                     dropped;
      logic                     final_vertex;
   } vertex_report_type;

   logic                  clock;
   logic                  reset;
   logic                  req_tvalid;
   logic                  req_tready;
   logic [31:0]           req_tdata;
   logic                  req_tlast;
   logic                  rsp_tvalid;
   logic                  rsp_tready;
   logic [47:0]           rsp_tdata;
   logic                  rsp_tlast;
   logic                  csr_psel;
   logic                  csr_penable;
   logic                  csr_pwrite;
   logic [CSR_ADDR_W-1:0] csr_paddr;
   logic [31:0]           csr_pwdata;
   logic [31:0]           csr_prdata;
   logic                  csr_pready;

   logic [ID_W-1:0]            arc_tail [ARC_CAP];
   logic [ID_W-1:0]            arc_head [ARC_CAP];
   logic signed [WEIGHT_W-1:0] arc_weight [ARC_CAP];
   int                         arc_count = 0;
   logic                       arcs_lost = 1'b0;
   logic [VC_W-1:0]            model_vc  = VC_RESET;
   logic [ID_W-1:0]            model_src = SRC_RESET;
   vertex_report_type          pending_vertices [$];

   int fail_count   = 0;
   int idle_cycles  = 0;
   int req_accepted = 0;
   int cur_vc       = VC_RESET;
   bit steady_flow  = 1'b0;
   int ready_hold   = 0;

   bellman_ford_shortest_paths_top dut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tlast   (req_tlast),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tlast   (rsp_tlast),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   function automatic int used_vertices(int vc);
      if (vc == 0)
         return 1;
      if (vc > VTX_CAP)
         return VTX_CAP;
      return vc;
   endfunction

   function automatic void solve_paths();
      int                       n;
      int                       src;
      int                       a;
      int                       b;
      longint                   sum;
      logic signed [DIST_W-1:0] cand;
      logic signed [DIST_W-1:0] dist_v [VTX_CAP];
      logic                     seen [VTX_CAP];
      logic [ID_W-1:0]          par [VTX_CAP];
      logic                     par_ok [VTX_CAP];
      vertex_report_type        r;
      n = used_vertices(model_vc);
      src = model_src;
      for (int v = 0; v < VTX_CAP; v++) begin
         dist_v[v] = '0;
         seen[v] = 1'b0;
         par[v] = '0;
         par_ok[v] = 1'b0;
      end
      if (src < n)
         seen[src] = 1'b1;
      for (int pass = 0; pass + 1 < n; pass++) begin
         for (int e = 0; e < arc_count; e++) begin
            a = arc_tail[e];
            b = arc_head[e];
            if (a >= n || b >= n || !seen[a])
               continue;
            sum = longint'(dist_v[a]) + longint'(arc_weight[e]);
            if (sum > 64'sd2147483647)
               cand = 32'sh7FFFFFFF;
            else if (sum < -64'sd2147483648)
               cand = 32'sh80000000;
            else
               cand = DIST_W'(sum);
            if (!seen[b] || dist_v[b] > cand) begin
               dist_v[b] = cand;
               seen[b] = 1'b1;
               par[b] = ID_W'(a);
               par_ok[b] = 1'b1;
            end
         end
      end
      for (int v = 0; v < n; v++) begin
         r.vertex = ID_W'(v);
         r.distance = seen[v] ? dist_v[v] : '0;
         r.reached = seen[v];
         r.parent = par_ok[v] ? par[v] : '0;
         r.has_parent = par_ok[v];
         r.dropped = arcs_lost;
         r.final_vertex = (v + 1 == n);
         pending_vertices = {pending_vertices, r};
      end
      arc_count = 0;
      arcs_lost = 1'b0;
   endfunction

   function automatic void store_arc(logic [31:0] data, logic last);
      if (arc_count < ARC_CAP) begin
         arc_tail[arc_count] = data[4:0];
         arc_head[arc_count] = data[9:5];
         arc_weight[arc_count] = data[25:10];
         arc_count++;
      end else begin
         arcs_lost = 1'b1;
      end
      if (last)
         solve_paths();
   endfunction

   function automatic void check_field(string name, longint want, longint got);
      if (want != got) begin
         $error("%s: expected %0d, actual %0d", name, want, got);
         fail_count++;
      end
   endfunction

   always @(posedge clock) begin : monitor
      logic              busy;
      vertex_report_type want;
      busy = 1'b0;
      if (reset) begin
         idle_cycles <= 0;
      end else begin
         if (csr_psel && csr_penable && csr_pwrite && csr_pready) begin
            busy = 1'b1;
            if (csr_paddr[2] == CSR_IDX_VC)
               model_vc = csr_pwdata[VC_W-1:0];
            else
               model_src = csr_pwdata[ID_W-1:0];
         end
         if (req_tvalid && req_tready) begin
            busy = 1'b1;
            store_arc(req_tdata, req_tlast);
            req_accepted <= req_accepted + 1;
         end
         if (rsp_tvalid && rsp_tready) begin
            busy = 1'b1;
            if (pending_vertices.size() == 0) begin
               $error("unexpected result for vertex_id %0d", rsp_tdata[4:0]);
               fail_count++;
            end else begin
               want = pending_vertices.pop_front();
               check_field("vertex_id", want.vertex, rsp_tdata[4:0]);
               check_field("path_distance", longint'(want.distance),
                           longint'($signed(rsp_tdata[36:5])));
               check_field("reached", want.reached, rsp_tdata[37]);
               check_field("parent_vertex", want.parent, rsp_tdata[42:38]);
               check_field("has_parent", want.has_parent, rsp_tdata[43]);
               check_field("edges_dropped", want.dropped, rsp_tdata[44]);
               check_field("last_vertex", want.final_vertex, rsp_tlast);
            end
         end
         idle_cycles <= busy ? 0 : idle_cycles + 1;
         if (idle_cycles >= IDLE_LIMIT) begin
            $display("Test completed with failures");
            $finish;
         end
      end
   end

   function automatic int idle_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 65)
         return 0;
      if (r < 92)
         return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   initial begin
      rsp_tready = 1'b0;
      forever begin
         @(negedge clock);
         if (ready_hold > 0) begin
            ready_hold--;
            rsp_tready = 1'b0;
         end else begin
            rsp_tready = 1'b1;
            if (!steady_flow && $urandom_range(0, 3) == 0)
               ready_hold = idle_gap();
         end
      end
   end

   task automatic send_arc(input int tail, input int head, input int weight,
                           input bit last);
      int gap;
      int seen_count;
      gap = steady_flow ? 0 : idle_gap();
      if (gap > 0) begin
         req_tvalid = 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_tdata = {6'b0, WEIGHT_W'(weight), ID_W'(head), ID_W'(tail)};
      req_tlast = last;
      req_tvalid = 1'b1;
      seen_count = req_accepted;
      do @(negedge clock); while (req_accepted == seen_count);
   endtask

   task automatic wait_drained();
      req_tvalid = 1'b0;
      while (pending_vertices.size() != 0)
         @(negedge clock);
      repeat (SETTLE) @(negedge clock);
   endtask

   task automatic write_reg(input logic [CSR_ADDR_W-1:0] addr, input int value);
      csr_paddr = addr;
      csr_pwdata = value;
      csr_pwrite = 1'b1;
      csr_psel = 1'b1;
      csr_penable = 1'b0;
      @(negedge clock);
      csr_penable = 1'b1;
      @(negedge clock);
      csr_psel = 1'b0;
      csr_penable = 1'b0;
   endtask

   task automatic configure(input int vc, input int src);
      wait_drained();
      write_reg(VC_ADDR, vc);
      write_reg(SRC_ADDR, src);
      cur_vc = vc;
   endtask

   task automatic test_reset_defaults();
      send_arc(1, 2, 5, 0);
      send_arc(2, 3, -3, 0);
      send_arc(1, 3, 4, 0);
      send_arc(3, 4, 7, 1);
   endtask

   task automatic test_vertex_count_bounds();
      configure(0, 0);
      send_arc(0, 0, -32768, 1);
      configure(1, 0);
      send_arc(0, 0, 5, 1);
      configure(63, 31);
      send_arc(31, 0, 32767, 0);
      send_arc(0, 31, -32768, 0);
      send_arc(0, 16, -1, 1);
   endtask

   task automatic test_weight_extremes();
      configure(32, 0);
      send_arc(0, 1, 32767, 0);
      send_arc(1, 2, 32767, 0);
      send_arc(0, 2, -32768, 0);
      send_arc(2, 31, 0, 0);
      send_arc(31, 30, -1, 1);
   endtask

   task automatic test_out_of_range();
      configure(4, 7);
      send_arc(0, 1, 3, 0);
      send_arc(1, 2, 3, 1);
      configure(4, 3);
      send_arc(3, 9, 1, 0);
      send_arc(12, 0, 2, 0);
      send_arc(3, 0, -4, 1);
   endtask

   task automatic test_negative_cycle();
      configure(5, 0);
      steady_flow = 1'b1;
      send_arc(0, 1, 2, 0);
      send_arc(1, 2, -6, 0);
      send_arc(2, 1, 1, 0);
      send_arc(2, 3, 4, 0);
      send_arc(3, 4, -32768, 1);
      steady_flow = 1'b0;
   endtask

   task automatic test_store_overflow();
      configure(3, 0);
      for (int i = 0; i < ARC_CAP + 3; i++)
         send_arc($urandom_range(0, 2), $urandom_range(0, 2),
                  int'($urandom_range(0, 70)) - 20, i == ARC_CAP + 2);
      send_arc(0, 1, 9, 1);
   endtask

   task automatic test_random_graphs();
      int sent;
      int arcs;
      int n;
      int r;
      int tail;
      int head;
      int weight;
      bit noisy;
      sent = 0;
      while (sent < RANDOM_ARCS) begin
         if ($urandom_range(0, 3) == 0) begin
            r = $urandom_range(0, 99);
            if (r < 70)
               n = $urandom_range(2, 12);
            else if (r < 85)
               n = $urandom_range(13, 32);
            else
               n = $urandom_range(0, 63);
            if ($urandom_range(0, 4) != 0)
               configure(n, $urandom_range(0, used_vertices(n) - 1));
            else
               configure(n, $urandom_range(0, 31));
         end else if ($urandom_range(0, 5) == 0) begin
            wait_drained();
         end
         if ($urandom_range(0, 9) == 0)
            steady_flow = !steady_flow;
         n = used_vertices(cur_vc);
         arcs = ($urandom_range(0, 7) == 0) ? $urandom_range(13, 40)
                                            : $urandom_range(1, 12);
         noisy = ($urandom_range(0, 9) == 0);
         for (int i = 0; i < arcs; i++) begin
            tail = (noisy || $urandom_range(0, 7) == 0) ? $urandom_range(0, 31)
                                                        : $urandom_range(0, n - 1);
            head = (noisy || $urandom_range(0, 7) == 0) ? $urandom_range(0, 31)
                                                        : $urandom_range(0, n - 1);
            r = $urandom_range(0, 99);
            if (r < 50)
               weight = int'($urandom_range(0, 120)) - 40;
            else if (r < 75)
               weight = int'($urandom_range(0, 2000)) - 1000;
            else
               weight = int'($urandom_range(0, 65535)) - 32768;
            send_arc(tail, head, weight, i == arcs - 1);
            sent++;
         end
      end
      steady_flow = 1'b0;
   endtask

   initial begin
      reset = 1'b1;
      req_tvalid = 1'b0;
      req_tdata = '0;
      req_tlast = 1'b0;
      csr_psel = 1'b0;
      csr_penable = 1'b0;
      csr_pwrite = 1'b0;
      csr_paddr = '0;
      csr_pwdata = '0;
      repeat (11) @(negedge clock);
      reset = 1'b0;
      test_reset_defaults();
      test_vertex_count_bounds();
      test_weight_extremes();
      test_out_of_range();
      test_negative_cycle();
      test_store_overflow();
      test_random_graphs();
      wait_drained();
      repeat (24) @(negedge clock);
      if (fail_count == 0 && pending_vertices.size() == 0)
         $display("Test completed successfully");
      else
         $display("Test completed with failures");
      $finish;
   end

endmodule
